// ===== hdl/ors_pkg.sv =====
// Shared types and codes for the 1-Wire ROM search engine.
`timescale 1ns / 1ps

package ors_pkg;

    localparam int RomBits  = 64;
    localparam int CrcBits  = 56;
    localparam logic [7:0] CrcPoly = 8'h8C;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_TRIPLET = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_DIRECTION   = 3'd0,
        ST_FOUND       = 3'd1,
        ST_NO_PRESENCE = 3'd2,
        ST_EXHAUSTED   = 3'd3,
        ST_NO_RESPONSE = 3'd4,
        ST_CRC_ERROR   = 3'd5,
        ST_IGNORED     = 3'd6,
        ST_SPARE       = 3'd7
    } status_t;

    typedef struct packed {
        action_t action;
        logic    presence;
        logic    first_bit;
        logic    complement_bit;
        logic    taken_direction;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        direction;
        logic [6:0]  bit_number;
        logic [63:0] rom_code;
        logic        last_device;
    } result_t;

    function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic din);
        logic mix;
        mix = crc[0] ^ din;
        return (crc >> 1) ^ (mix ? CrcPoly : 8'h00);
    endfunction

endpackage

// ===== hdl/ors_in_stage.sv =====
// Input register that holds one accepted item for the search core.
`timescale 1ns / 1ps

module ors_in_stage
    import ors_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/ors_search_core.sv =====
// Search state and the per-item update that forms one result.
`timescale 1ns / 1ps

module ors_search_core
    import ors_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    logic [63:0] rom_reg, rom_next;
    logic [6:0]  last_disc_reg, last_disc_next;
    logic [6:0]  pass_zero_reg, pass_zero_next;
    logic [6:0]  bit_pos_reg, bit_pos_next;
    logic        exhausted_reg, exhausted_next;
    logic        in_pass_reg, in_pass_next;
    logic [7:0]  crc_reg, crc_next;

    logic [5:0]  bit_idx;
    logic [6:0]  bit_inc;
    logic [6:0]  zero_upd;
    logic [63:0] rom_upd;
    logic [7:0]  crc_byte;

    assign bit_idx  = bit_pos_reg[5:0] - 6'd1;
    assign bit_inc  = bit_pos_reg + 7'd1;
    assign zero_upd = (!item.first_bit && !item.complement_bit && !item.taken_direction)
                      ? bit_pos_reg : pass_zero_reg;
    assign crc_byte = {item.taken_direction, rom_reg[62:56]};

    always_comb begin
        rom_upd          = rom_reg;
        rom_upd[bit_idx] = item.taken_direction;
    end

    always_comb begin
        rom_next       = rom_reg;
        last_disc_next = last_disc_reg;
        pass_zero_next = pass_zero_reg;
        bit_pos_next   = bit_pos_reg;
        exhausted_next = exhausted_reg;
        in_pass_next   = in_pass_reg;
        crc_next       = crc_reg;
        result         = '0;
        result.status  = ST_IGNORED;

        unique case (item.action)
            ACT_START: begin
                if (exhausted_reg) begin
                    in_pass_next  = 1'b0;
                    result.status = ST_EXHAUSTED;
                end else if (!item.presence) begin
                    rom_next       = '0;
                    last_disc_next = '0;
                    exhausted_next = 1'b0;
                    in_pass_next   = 1'b0;
                    result.status  = ST_NO_PRESENCE;
                end else begin
                    in_pass_next      = 1'b1;
                    bit_pos_next      = 7'd1;
                    pass_zero_next    = '0;
                    crc_next          = '0;
                    result.status     = ST_DIRECTION;
                    result.bit_number = 7'd1;
                    if (last_disc_reg > 7'd1) begin
                        result.direction = rom_reg[0];
                    end else begin
                        result.direction = (last_disc_reg == 7'd1);
                    end
                end
            end
            ACT_CLEAR: begin
                rom_next       = '0;
                last_disc_next = '0;
                exhausted_next = 1'b0;
                in_pass_next   = 1'b0;
            end
            ACT_TRIPLET: begin
                if (in_pass_reg) begin
                    if (item.first_bit && item.complement_bit) begin
                        in_pass_next  = 1'b0;
                        result.status = ST_NO_RESPONSE;
                    end else begin
                        pass_zero_next = zero_upd;
                        rom_next       = rom_upd;
                        if (bit_pos_reg <= 7'(CrcBits)) begin
                            crc_next = crc8_bit(crc_reg, item.taken_direction);
                        end
                        if (bit_pos_reg < 7'(RomBits)) begin
                            bit_pos_next      = bit_inc;
                            result.status     = ST_DIRECTION;
                            result.bit_number = bit_inc;
                            if (bit_inc < last_disc_reg) begin
                                result.direction = rom_reg[bit_pos_reg[5:0]];
                            end else begin
                                result.direction = (bit_inc == last_disc_reg);
                            end
                        end else begin
                            in_pass_next = 1'b0;
                            if (crc_reg != crc_byte) begin
                                result.status = ST_CRC_ERROR;
                            end else begin
                                last_disc_next     = zero_upd;
                                exhausted_next     = (zero_upd == 7'd0);
                                result.status      = ST_FOUND;
                                result.rom_code    = rom_upd;
                                result.last_device = (zero_upd == 7'd0);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_reg       <= '0;
            last_disc_reg <= '0;
            pass_zero_reg <= '0;
            bit_pos_reg   <= '0;
            exhausted_reg <= 1'b0;
            in_pass_reg   <= 1'b0;
            crc_reg       <= '0;
        end else if (advance) begin
            rom_reg       <= rom_next;
            last_disc_reg <= last_disc_next;
            pass_zero_reg <= pass_zero_next;
            bit_pos_reg   <= bit_pos_next;
            exhausted_reg <= exhausted_next;
            in_pass_reg   <= in_pass_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

// ===== hdl/ors_out_stage.sv =====
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module ors_out_stage
    import ors_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  result_t result,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== hdl/onewire_rom_search_engine.sv =====
// Top level of the 1-Wire ROM search engine with its stream ports.
//
// Channel  Direction  Carries
// s_       in         action in tuser, bus reset and triplet reply bits in tdata
// m_       out        status in tuser, direction request or found code in tdata
//
// Each item passes through the input register and then the result register; a new item
// can be taken every cycle while the result register is not stalled.
// The whole per-item update, including one CRC step, sits between those registers.
// Reset is synchronous on aresetn and clears the search state and both valid flags.
// A stalled result register holds the item in the input register and then drops s_tready.
`timescale 1ns / 1ps

module onewire_rom_search_engine
    import ors_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // presence, first_bit, complement_bit, taken_direction, zeros
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // direction, bit_number, rom_code
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t m_result;

    always_comb begin
        s_item.action          = action_t'(s_tuser);
        s_item.presence        = s_tdata[0];
        s_item.first_bit       = s_tdata[1];
        s_item.complement_bit  = s_tdata[2];
        s_item.taken_direction = s_tdata[3];
    end

    assign advance = item_valid && (!m_tvalid || m_tready);

    ors_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ors_search_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    ors_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {m_result.rom_code, m_result.bit_number, m_result.direction};
    assign m_tuser = m_result.status;
    assign m_tlast = m_result.last_device;

    // The last-device flag only comes with a found code.
    a_last_only_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == ST_FOUND)
        else $error("last_device set on a result that is not a found code");

    // A direction request names a ROM bit from 1 to 64 and carries no code.
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DIRECTION |->
            m_tdata[7:1] != 7'd0 && m_tdata[7:1] <= 7'd64 && m_tdata[71:8] == 64'd0)
        else $error("direction request with bad bit number or stray code");

    // The input side only stalls while a result waits on the output side.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

    // A processed item always leaves a result in the register on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item produced no result");

endmodule
